/* hdl/multi_channel_timeout_monitor_defines.svh */
// Assertion helpers used by the checker file.
`ifndef MULTI_CHANNEL_TIMEOUT_MONITOR_DEFINES_SVH
`define MULTI_CHANNEL_TIMEOUT_MONITOR_DEFINES_SVH

// same-cycle implication, off during reset
`define MCTM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mctm assertion failed");

// next-cycle implication, off during reset
`define MCTM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mctm assertion failed");

// next-cycle implication, always on
`define MCTM_ASSERT_NEXT_ON(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mctm assertion failed");

`endif

/* hdl/mctm_pkg.sv */
package mctm_pkg;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 8;
    localparam int OP_W      = 3;
    localparam int PADDR_W   = 3;

    localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_FEED  = 3'd1;
    localparam logic [OP_W-1:0] OP_SCAN  = 3'd2;
    localparam logic [OP_W-1:0] OP_ENALL = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

    localparam logic [PADDR_W-1:0] ADDR_IGNORED = 3'd0;
    localparam logic [5:0]         IGN_RESET    = 6'd63;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    typedef enum logic [2:0] {
        K_INIT  = 3'd0,
        K_FEED  = 3'd1,
        K_SCAN  = 3'd2,
        K_ENALL = 3'd3,
        K_QUERY = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  ch;
        logic        vld;
        logic [31:0] now;
        logic [31:0] start_to;
        logic [31:0] run_to;
        logic        close_on;
        logic [31:0] close_to;
    } t_cmd;

    typedef struct packed {
        logic [3:0] ch;
        logic       ev;
        logic       cl;
        logic       ef;
        logic       last;
    } t_result;

endpackage

/* hdl/multi_channel_timeout_monitor.sv */
// Channel   | Handshake          | Payload
// s_axis    | tvalid/tready      | tuser = op, tdata = channel .. close_timeout
// m_axis    | tvalid/tready      | tdata = out_channel .. err_flag, tlast = last
// apb       | psel/penable/pwrite| reg 0 at 0x0: ignored_channel
// Scan: one channel per cycle, unless the result output stalls, through a 3-stage
// compare pipeline; init, feed, enable-all and query each give a single result.
// The back end starts the next item only once the scan pipeline has drained.
// Reset is synchronous, active low, and clears all channel flags at once.
// A 2-deep command queue lets inputs be taken while results stall.
module multi_channel_timeout_monitor #(
    parameter int CHANNELS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [3:0] channel, [35:4] now, [67:36] start_timeout, [99:68] run_timeout,
    // [100] close_on, [132:101] close_timeout, [135:133] zero
    input  logic [mctm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [2:0] op
    input  logic [mctm_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [3:0] out_channel, [4] err_event, [5] close_event, [6] err_flag, [7] zero
    output logic [mctm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mctm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import mctm_pkg::*;

    logic    front_valid, q_ready, q_valid, q_pop;
    t_cmd    front_cmd, q_cmd;
    t_result res;

    mctm_front #(.CHANNELS(CHANNELS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_cmd_valid   (front_valid),
        .o_cmd         (front_cmd),
        .i_cmd_ready   (q_ready)
    );

    mctm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    mctm_back #(.CHANNELS(CHANNELS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, res.ef, res.cl, res.ev, res.ch};
    assign m_axis_tlast = res.last;

endmodule

/* hdl/mctm_front.sv */
module mctm_front #(
    parameter int CHANNELS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // channel, now, start_timeout, run_timeout, close_on, close_timeout, pad
    input  logic [mctm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // op
    input  logic [mctm_pkg::OP_W-1:0]        s_axis_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mctm_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic                             o_cmd_valid,
    output mctm_pkg::t_cmd                   o_cmd,
    input  logic                             i_cmd_ready
);
    import mctm_pkg::*;

    localparam logic [6:0] CH_LIM = 7'(CHANNELS);

    logic [5:0] r_ign;
    logic       ch_ok;
    logic       known;
    t_kind      kind;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_IGNORED) ? {26'd0, r_ign} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ign <= IGN_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_IGNORED) begin
            r_ign <= pwdata[5:0];
        end
    end

    assign ch_ok = ({3'd0, s_axis_tdata[3:0]} < CH_LIM);

    // invalid init/feed and ignored feeds only answer, like a query
    always_comb begin
        known = 1'b1;
        kind  = K_QUERY;
        unique case (s_axis_tuser)
            OP_INIT:  kind = ch_ok ? K_INIT : K_QUERY;
            OP_FEED:  kind = (ch_ok && {2'd0, s_axis_tdata[3:0]} != r_ign) ? K_FEED : K_QUERY;
            OP_SCAN:  kind = K_SCAN;
            OP_ENALL: kind = K_ENALL;
            OP_QUERY: kind = K_QUERY;
            default:  known = 1'b0;
        endcase
    end

    assign s_axis_tready = i_cmd_ready;
    assign o_cmd_valid   = s_axis_tvalid && known;

    always_comb begin
        o_cmd.kind     = kind;
        o_cmd.ch       = s_axis_tdata[3:0];
        o_cmd.vld      = ch_ok;
        o_cmd.now      = s_axis_tdata[35:4];
        o_cmd.start_to = s_axis_tdata[67:36];
        o_cmd.run_to   = s_axis_tdata[99:68];
        o_cmd.close_on = s_axis_tdata[100];
        o_cmd.close_to = s_axis_tdata[132:101];
    end

endmodule

/* hdl/mctm_fifo.sv */
module mctm_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mctm_pkg::t_cmd i_data,
    output logic           o_ready,
    output logic           o_valid,
    output mctm_pkg::t_cmd o_data,
    input  logic           i_pop
);
    import mctm_pkg::*;

    localparam logic [FIFO_CNT_W-1:0] FULL = FIFO_CNT_W'(FIFO_DEPTH);

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp;
    logic [FIFO_PTR_W-1:0] r_rp;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_ready = (r_cnt != FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hdl/mctm_back.sv */
module mctm_back #(
    parameter int CHANNELS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  mctm_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_res_valid,
    output mctm_pkg::t_result o_res,
    input  logic              i_res_ready
);
    import mctm_pkg::*;

    localparam int          IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [IW-1:0] LAST = IW'(CHANNELS - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state r_state;
    logic [IW-1:0] r_idx;
    logic [31:0]   r_now;

    logic [31:0]   r_stamp_mem [CHANNELS];
    logic [95:0]   r_lim_mem   [CHANNELS];
    logic [CHANNELS-1:0] r_stamp_ok, r_lim_ok;
    logic [CHANNELS-1:0] r_sp, r_run, r_err, r_ce;

    // stage 1: memory read data
    logic          r_s1_vld, r_s1_last, r_s1_sok, r_s1_lok;
    logic [IW-1:0] r_s1_idx;
    logic [31:0]   r_s1_stamp;
    logic [95:0]   r_s1_lim;
    // stage 2: elapsed and chosen limit
    logic          r_s2_vld, r_s2_last, r_s2_chk, r_s2_start, r_s2_ce;
    logic [IW-1:0] r_s2_idx;
    logic [31:0]   r_s2_elapsed, r_s2_limit, r_s2_close;
    // stage 3: compare and overshoot
    logic          r_s3_vld, r_s3_last, r_s3_chk, r_s3_start, r_s3_ce, r_s3_gt;
    logic [IW-1:0] r_s3_idx;
    logic [31:0]   r_s3_over, r_s3_close;

    logic    r_out_vld;
    t_result r_out;

    logic          adv, pipe_empty, pop, ns_fire, issue;
    logic [IW+3:0] ch_ext, idx_ext;
    logic [IW-1:0] c;
    logic          ns_ef;
    logic [31:0]   s1_stamp, s1_start, s1_runl, s1_close;
    logic          s1_in_start, s1_chk;
    logic          s3_ev, s3_cl;
    t_result       s3_res, ns_res;

    assign adv        = !r_out_vld || i_res_ready;
    assign pipe_empty = !r_s1_vld && !r_s2_vld && !r_s3_vld;
    assign pop        = i_cmd_valid && (r_state == ST_IDLE) && pipe_empty && adv;
    assign ns_fire    = pop && (i_cmd.kind != K_SCAN);
    assign issue      = (r_state == ST_SCAN) && adv;
    assign o_cmd_pop  = pop;

    assign ch_ext = {{IW{1'b0}}, i_cmd.ch};
    assign c      = ch_ext[IW-1:0];
    assign ns_ef  = i_cmd.vld && (i_cmd.kind != K_FEED) && r_err[c];

    always_comb begin
        ns_res.ch   = i_cmd.ch;
        ns_res.ev   = 1'b0;
        ns_res.cl   = 1'b0;
        ns_res.ef   = ns_ef;
        ns_res.last = 1'b1;
    end

    assign s1_stamp    = r_s1_sok ? r_s1_stamp : 32'd0;
    assign s1_start    = r_s1_lok ? r_s1_lim[95:64] : 32'd0;
    assign s1_runl     = r_s1_lok ? r_s1_lim[63:32] : 32'd0;
    assign s1_close    = r_s1_lok ? r_s1_lim[31:0]  : 32'd0;
    assign s1_in_start = r_sp[r_s1_idx] && (s1_start != 32'd0);
    assign s1_chk      = s1_in_start || (r_run[r_s1_idx] && s1_runl != 32'd0);

    assign s3_ev = r_s3_chk && r_s3_gt;
    assign s3_cl = r_s3_chk && (r_s3_gt ? (r_s3_ce && r_s3_over > r_s3_close)
                                        : (!r_s3_start && r_s3_ce));

    assign idx_ext = {4'd0, r_s3_idx};
    always_comb begin
        s3_res.ch   = idx_ext[3:0];
        s3_res.ev   = s3_ev;
        s3_res.cl   = s3_cl;
        s3_res.ef   = r_err[r_s3_idx] || s3_ev;
        s3_res.last = r_s3_last;
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.kind == K_INIT) begin
            r_stamp_mem[c] <= 32'd0;
            r_lim_mem[c]   <= {i_cmd.start_to, i_cmd.run_to, i_cmd.close_to};
        end else if (pop && i_cmd.kind == K_FEED) begin
            r_stamp_mem[c] <= i_cmd.now;
        end
        if (pop) begin
            r_now <= i_cmd.now;
        end
        if (issue) begin
            r_s1_stamp <= r_stamp_mem[r_idx];
            r_s1_lim   <= r_lim_mem[r_idx];
            r_s1_sok   <= r_stamp_ok[r_idx];
            r_s1_lok   <= r_lim_ok[r_idx];
            r_s1_idx   <= r_idx;
            r_s1_last  <= (r_idx == LAST);
        end
        if (adv) begin
            r_s2_idx     <= r_s1_idx;
            r_s2_last    <= r_s1_last;
            r_s2_chk     <= s1_chk;
            r_s2_start   <= s1_in_start;
            r_s2_ce      <= r_ce[r_s1_idx];
            r_s2_elapsed <= r_now - s1_stamp;
            r_s2_limit   <= s1_in_start ? s1_start : s1_runl;
            r_s2_close   <= s1_close;

            r_s3_idx   <= r_s2_idx;
            r_s3_last  <= r_s2_last;
            r_s3_chk   <= r_s2_chk;
            r_s3_start <= r_s2_start;
            r_s3_ce    <= r_s2_ce;
            r_s3_gt    <= r_s2_elapsed > r_s2_limit;
            r_s3_over  <= r_s2_elapsed - r_s2_limit;
            r_s3_close <= r_s2_close;

            if (ns_fire) begin
                r_out <= ns_res;
            end else if (r_s3_vld) begin
                r_out <= s3_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_stamp_ok <= '0;
            r_lim_ok   <= '0;
            r_sp       <= '0;
            r_run      <= '0;
            r_err      <= '0;
            r_ce       <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (pop && i_cmd.kind == K_SCAN) begin
                        r_state <= ST_SCAN;
                        r_idx   <= '0;
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        if (r_idx == LAST) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (adv) begin
                r_s1_vld  <= issue;
                r_s2_vld  <= r_s1_vld;
                r_s3_vld  <= r_s2_vld;
                r_out_vld <= ns_fire || r_s3_vld;
            end

            if (pop) begin
                case (i_cmd.kind)
                    K_INIT: begin
                        r_sp[c]       <= 1'b1;
                        r_run[c]      <= 1'b0;
                        r_ce[c]       <= i_cmd.close_on;
                        r_stamp_ok[c] <= 1'b1;
                        r_lim_ok[c]   <= 1'b1;
                    end
                    K_FEED: begin
                        r_run[c]      <= 1'b1;
                        r_sp[c]       <= 1'b0;
                        r_err[c]      <= 1'b0;
                        r_stamp_ok[c] <= 1'b1;
                    end
                    K_ENALL: r_run <= '1;
                    default: ;
                endcase
            end

            if (adv && r_s3_vld && s3_ev) begin
                r_err[r_s3_idx] <= 1'b1;
                if (s3_cl) begin
                    if (r_s3_start) begin
                        r_sp[r_s3_idx] <= 1'b0;
                    end else begin
                        r_run[r_s3_idx] <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

endmodule

/* hdl/mctm_checker.sv */
`include "multi_channel_timeout_monitor_defines.svh"

module mctm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [mctm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);

    `MCTM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // an error event always leaves the error flag set
    `MCTM_ASSERT_IMP(a_err_sets_flag, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[4], m_axis_tdata[6])

    `MCTM_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, !m_axis_tdata[7])

    `MCTM_ASSERT_NEXT_ON(a_rst_clears_out, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind multi_channel_timeout_monitor mctm_checker u_mctm_checker (.*);
